// ----- rtl/core/outstanding_request_tag_table_macros.svh -----
// Assertion macros shared by the tag table RTL.
`ifndef OUTSTANDING_REQUEST_TAG_TABLE_MACROS_SVH
`define OUTSTANDING_REQUEST_TAG_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ORTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define ORTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ortt_pkg.sv -----
// Types, field widths and codes of the outstanding request tag table.
package ortt_pkg;

    localparam int ORTT_CAPACITY = 64;

    localparam int REQ_TYPE_W = 2;
    localparam int CLIENT_W   = 8;
    localparam int COMMAND_W  = 15;
    localparam int DATA_W     = 32;
    localparam int TAG_IN_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int TAG_OUT_W  = 6;
    localparam int COUNT_W    = 7;

    // Request types.
    localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_COUNT   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

    typedef struct packed {
        logic [CLIENT_W-1:0]  client;
        logic [COMMAND_W-1:0] command;
        logic [DATA_W-1:0]    data;
    } ortt_entry_t;

    typedef struct packed {
        logic client_eq;
        logic entry_eq;
    } ortt_hit_t;

endpackage

// ----- rtl/core/ortt_req_if.sv -----
// Request channel of the tag table.
interface ortt_req_if import ortt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [CLIENT_W-1:0]   client_id;
    logic [COMMAND_W-1:0]  command_code;
    logic [DATA_W-1:0]     data_handle;
    logic [TAG_IN_W-1:0]   tag_in;

    modport source (output valid, req_type, client_id, command_code, data_handle, tag_in,
                    input ready);
    modport sink   (input valid, req_type, client_id, command_code, data_handle, tag_in,
                    output ready);
endinterface

// ----- rtl/core/ortt_rsp_if.sv -----
// Response channel of the tag table.
interface ortt_rsp_if import ortt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [TAG_OUT_W-1:0] tag_out;
    logic [DATA_W-1:0]    data_out;
    logic [COUNT_W-1:0]   client_count;

    modport source (output valid, status, tag_out, data_out, client_count, input ready);
    modport sink   (input valid, status, tag_out, data_out, client_count, output ready);
endinterface

// ----- rtl/core/ortt_store.sv -----
// Slot storage with one write port, one registered read port and the shared entry compare.
module ortt_store import ortt_pkg::*; #(
    parameter int CAPACITY = ORTT_CAPACITY,
    localparam int IDX_W = $clog2(CAPACITY)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ortt_entry_t          wr_entry,
    input  logic [IDX_W-1:0]     rd_addr,
    input  logic [CLIENT_W-1:0]  key_client,
    input  logic [COMMAND_W-1:0] key_command,
    output logic [DATA_W-1:0]    rd_data,
    output ortt_hit_t            hit
);

    ortt_entry_t mem [CAPACITY];
    ortt_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_data      = rd_entry_reg.data;
    assign hit.client_eq = (rd_entry_reg.client == key_client);
    assign hit.entry_eq  = hit.client_eq && (rd_entry_reg.command == key_command);

endmodule

// ----- rtl/core/outstanding_request_tag_table.sv -----
// Outstanding request tag table: one request at a time, ready only while idle.
// Allocate and release: executed in the exec or check state once the response register
// is free, which registers the result; no new request is accepted before that.
// Count: one slot read per cycle over the grown slots, its compare registered behind it;
// the total is loaded once the scan drains and the response register is free.
// Reset clears all busy bits, sets the grown size to one and the hint to zero.
module outstanding_request_tag_table import ortt_pkg::*; #(
    parameter int CAPACITY = ORTT_CAPACITY
) (
    input  logic clk,
    input  logic rst_n,
    ortt_req_if.sink   req,
    ortt_rsp_if.source rsp
);

    `include "outstanding_request_tag_table_macros.svh"

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_CNT  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [REQ_TYPE_W-1:0] type_reg;
    logic [CLIENT_W-1:0]   client_reg;
    logic [COMMAND_W-1:0]  cmd_reg;
    logic [DATA_W-1:0]     data_reg;
    logic [TAG_IN_W-1:0]   tag_reg;

    logic [CAPACITY-1:0] busy_reg, busy_next;
    logic [CNT_W-1:0]    grown_reg, grown_next;
    logic [IDX_W-1:0]    hint_reg, hint_next;

    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] acc_reg, acc_next;
    logic             pipe_v_reg, pipe_v_next;
    logic             pipe_busy_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [TAG_OUT_W-1:0] tag_out_reg;
    logic [DATA_W-1:0]    data_out_reg;
    logic [COUNT_W-1:0]   count_out_reg;

    logic                 load_out;
    logic [STATUS_W-1:0]  res_status;
    logic [TAG_OUT_W-1:0] res_tag;
    logic [DATA_W-1:0]    res_data;
    logic [COUNT_W-1:0]   res_count;

    logic             accept, out_free;
    logic             hint_ok, alloc_ok, alloc_grow;
    logic [IDX_W-1:0] alloc_slot, alloc_hint;
    logic [CNT_W-1:0] grown_after, hint_inc;
    logic [IDX_W-1:0] tag_idx;
    logic             tag_in_range;
    logic             scan_issue;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    ortt_hit_t        hit;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign tag_idx      = tag_reg[IDX_W-1:0];
    assign tag_in_range = (9'(tag_reg) < 9'(grown_reg));
    assign scan_issue   = (scan_reg < grown_reg);

    // Slot choice for an allocate: free hint slot, then slot zero, then growth, else full.
    always_comb
    begin
        hint_ok    = (hint_reg != '0) && (CNT_W'(hint_reg) < grown_reg) && !busy_reg[hint_reg];
        alloc_ok   = 1'b1;
        alloc_grow = 1'b0;
        alloc_slot = '0;
        if (hint_ok)
        begin
            alloc_slot = hint_reg;
        end
        else if (!busy_reg[0])
        begin
            alloc_slot = '0;
        end
        else if (grown_reg < CNT_W'(CAPACITY))
        begin
            alloc_slot = grown_reg[IDX_W-1:0];
            alloc_grow = 1'b1;
        end
        else
        begin
            alloc_ok = 1'b0;
        end
        grown_after = alloc_grow ? grown_reg + CNT_W'(1) : grown_reg;
        hint_inc    = CNT_W'(alloc_slot) + CNT_W'(1);
        if (alloc_grow || (hint_inc >= grown_after))
        begin
            alloc_hint = '0;
        end
        else
        begin
            alloc_hint = hint_inc[IDX_W-1:0];
        end
    end

    assign wr_en = (state_reg == ST_EXEC) && (type_reg == REQ_ALLOC) && alloc_ok && out_free;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: rd_addr = req.tag_in[IDX_W-1:0];
            ST_CNT:  rd_addr = scan_reg[IDX_W-1:0];
            default: rd_addr = tag_idx;
        endcase
    end

    ortt_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk         (clk),
        .wr_en       (wr_en),
        .wr_addr     (alloc_slot),
        .wr_entry    ({client_reg, cmd_reg, data_reg}),
        .rd_addr     (rd_addr),
        .key_client  (client_reg),
        .key_command (cmd_reg),
        .rd_data     (rd_data),
        .hit         (hit)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        grown_next     = grown_reg;
        hint_next      = hint_reg;
        scan_next      = scan_reg;
        acc_next       = acc_reg;
        pipe_v_next    = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        load_out       = 1'b0;
        res_status     = STAT_OK;
        res_tag        = '0;
        res_data       = '0;
        res_count      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_next = '0;
                    acc_next  = '0;
                    case (req.req_type)
                        REQ_RELEASE: state_next = ST_CHK;
                        REQ_COUNT:   state_next = ST_CNT;
                        default:     state_next = ST_EXEC;
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (type_reg == REQ_ALLOC)
                    begin
                        if (alloc_ok)
                        begin
                            busy_next[alloc_slot] = 1'b1;
                            grown_next = grown_after;
                            hint_next  = alloc_hint;
                            res_tag    = TAG_OUT_W'(alloc_slot);
                        end
                        else
                        begin
                            res_status = STAT_FULL;
                        end
                    end
                end
            end
            ST_CHK:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    res_status = STAT_MISS;
                    if (tag_in_range)
                    begin
                        hint_next = tag_idx;
                        if (busy_reg[tag_idx] && hit.entry_eq)
                        begin
                            busy_next[tag_idx] = 1'b0;
                            res_status = STAT_OK;
                            res_data   = rd_data;
                        end
                    end
                end
            end
            ST_CNT:
            begin
                // One slot read issues per cycle; its compare lands in the next cycle.
                if (pipe_v_reg && pipe_busy_reg && hit.client_eq)
                begin
                    acc_next = acc_reg + CNT_W'(1);
                end
                if (scan_issue)
                begin
                    scan_next   = scan_reg + CNT_W'(1);
                    pipe_v_next = 1'b1;
                end
                else if (!pipe_v_reg && out_free)
                begin
                    load_out   = 1'b1;
                    res_count  = COUNT_W'(acc_reg);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= '0;
            grown_reg     <= CNT_W'(1);
            hint_reg      <= '0;
            scan_reg      <= '0;
            acc_reg       <= '0;
            pipe_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            grown_reg     <= grown_next;
            hint_reg      <= hint_next;
            scan_reg      <= scan_next;
            acc_reg       <= acc_next;
            pipe_v_reg    <= pipe_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg   <= req.req_type;
            client_reg <= req.client_id;
            cmd_reg    <= req.command_code;
            data_reg   <= req.data_handle;
            tag_reg    <= req.tag_in;
        end
        pipe_busy_reg <= busy_reg[scan_reg[IDX_W-1:0]];
        if (load_out)
        begin
            status_reg    <= res_status;
            tag_out_reg   <= res_tag;
            data_out_reg  <= res_data;
            count_out_reg <= res_count;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.tag_out      = tag_out_reg;
    assign rsp.data_out     = data_out_reg;
    assign rsp.client_count = count_out_reg;

    `ORTT_ASSERT_IMP(a_grown_range, 1'b1,
        (grown_reg != '0) && (grown_reg <= CNT_W'(CAPACITY)),
        "grown size left its legal range")
    `ORTT_ASSERT_IMP(a_full_at_capacity, rsp.valid && (rsp.status == STAT_FULL),
        grown_reg == CNT_W'(CAPACITY), "table full reported below capacity")
    `ORTT_ASSERT_IMP(a_count_bounded, state_reg == ST_CNT,
        (acc_reg <= scan_reg) && (scan_reg <= grown_reg), "count scan ran past its bounds")
    `ORTT_ASSERT_NXT(a_alloc_marks_busy, wr_en,
        busy_reg[$past(alloc_slot)], "allocated slot not marked busy")

endmodule
